[hw/rtl/thss_pkg.sv]
// Shared codes, constants and types of the temperature and humidity sensor sequencer.
package thss_pkg;

  // Event kinds carried on the input stream.
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_REQUEST = 2'd1;
  localparam logic [1:0] MODE_DONE    = 2'd2;
  localparam logic [1:0] MODE_TIMER   = 2'd3;

  // Actions requested of the bus and timer logic.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_WRITE  = 3'd1;
  localparam logic [2:0] ACT_READ   = 3'd2;
  localparam logic [2:0] ACT_WAIT   = 3'd3;
  localparam logic [2:0] ACT_REPORT = 3'd4;

  // Pending command, which is part of the sequencer state.
  localparam logic [2:0] PC_NONE     = 3'd0;
  localparam logic [2:0] PC_SRESET   = 3'd1;
  localparam logic [2:0] PC_CLEAR    = 3'd2;
  localparam logic [2:0] PC_HEAT_ON  = 3'd3;
  localparam logic [2:0] PC_HEAT_OFF = 3'd4;
  localparam logic [2:0] PC_MSTART   = 3'd5;
  localparam logic [2:0] PC_READ     = 3'd6;

  // Sensor command words.
  localparam logic [15:0] CMD_SRESET   = 16'h30A2;
  localparam logic [15:0] CMD_CLEAR    = 16'h3041;
  localparam logic [15:0] CMD_HEAT_ON  = 16'h306D;
  localparam logic [15:0] CMD_HEAT_OFF = 16'h3066;
  localparam logic [15:0] CMD_MSTART   = 16'h2400;

  // Request status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_INIT  = 2'd1;
  localparam logic [1:0] STATUS_BUSY     = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_HEATER       = 2'd0;
  localparam logic [1:0] CFG_RESET_WAIT   = 2'd1;
  localparam logic [1:0] CFG_MEASURE_WAIT = 2'd2;
  localparam logic [7:0] RESET_WAIT_INIT   = 8'd2;
  localparam logic [7:0] MEASURE_WAIT_INIT = 8'd16;

  // Conversion gains: 175 degrees and 100 percent in hundredths, full scale 65535.
  localparam logic [14:0] TEMP_GAIN   = 15'd17500;
  localparam logic [13:0] HUM_GAIN    = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Widths of the scaled raw words.
  localparam int TEMP_PROD_W = 31;
  localparam int HUM_PROD_W  = 30;

  // Configuration register contents.
  typedef struct packed {
    logic       heater_enable;
    logic [7:0] reset_wait_ms;
    logic [7:0] measure_wait_ms;
  } cfg_t;

  // Decision of the sequencer for one event.
  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] command_word;
    logic [7:0]  wait_ms;
    logic [1:0]  request_status;
    logic        ready_res;
    logic        report;
  } seq_res_t;

endpackage

[hw/rtl/temp_humidity_sensor_sequencer_core.sv]
// Top level of the temperature and humidity sensor sequencer: ports, registers and stages.
// Each event transfer on the input stream (kind in s_axis_tuser) yields exactly one result
// transfer naming the next action: a command word to write, a six-byte read, a timed wait,
// or a report of temperature in hundredths of a degree and humidity in hundredths of a
// percent. One event is taken every cycle while the result stream keeps up. An event taken
// is held in the input register, where the raw words are scaled by their constant gains, and
// then moves on to the result register, which is loaded with the sequencer decision and
// the division by 65535 once that register is free.
// Backpressure on the result stream reaches s_axis_tready in the same cycle.
// Configuration writes are accepted at any time and should be made while the block is idle.
module temp_humidity_sensor_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_temperature[15:0], raw_humidity[31:16]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // command_word[15:0], wait_ms[23:16], temperature[38:24], humidity[52:39],
  // request_status[54:53], ready_res[55]
  output logic [55:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // action[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import thss_pkg::*;

  cfg_t cfg;

  logic                   in_valid;
  logic [1:0]             in_mode;
  logic [TEMP_PROD_W-1:0] in_temp_prod;
  logic [HUM_PROD_W-1:0]  in_hum_prod;
  logic                   in_advance;
  logic                   out_free;

  logic                   out_valid;
  logic [55:0]            out_data;
  logic [2:0]             out_action;

  seq_res_t               res;
  logic signed [14:0]     conv_temperature;
  logic [13:0]            conv_humidity;
  logic [14:0]            rep_temperature;
  logic [13:0]            rep_humidity;

  // Configuration registers; writes are always taken, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heater_enable   <= 1'b0;
      cfg.reset_wait_ms   <= RESET_WAIT_INIT;
      cfg.measure_wait_ms <= MEASURE_WAIT_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEATER:       cfg.heater_enable   <= cfg_data[0];
        CFG_RESET_WAIT:   cfg.reset_wait_ms   <= cfg_data;
        CFG_MEASURE_WAIT: cfg.measure_wait_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage handshakes: each register takes a new transfer when it is empty or draining.
  assign out_free      = !out_valid || m_axis_tready;
  assign in_advance    = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register: event kind and raw words scaled by their gains.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode      <= s_axis_tuser;
      in_temp_prod <= TEMP_PROD_W'(s_axis_tdata[15:0]) * TEMP_PROD_W'(TEMP_GAIN);
      in_hum_prod  <= HUM_PROD_W'(s_axis_tdata[31:16]) * HUM_PROD_W'(HUM_GAIN);
    end
  end

  // Sequencer decision and state.
  thss_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (in_advance),
    .mode    (in_mode),
    .cfg     (cfg),
    .res     (res)
  );

  // Conversion of the scaled words.
  thss_conv u_conv (
    .temp_prod   (in_temp_prod),
    .hum_prod    (in_hum_prod),
    .temperature (conv_temperature),
    .humidity    (conv_humidity)
  );

  // Report fields read as zero unless a report is given.
  assign rep_temperature = res.report ? conv_temperature : 15'd0;
  assign rep_humidity    = res.report ? conv_humidity : 14'd0;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      out_action <= res.action;
      out_data   <= {res.ready_res, res.request_status, rep_humidity, rep_temperature,
                     res.wait_ms, res.command_word};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_action;

endmodule

[hw/rtl/thss_conv.sv]
// Conversion of scaled raw words to hundredths of a degree and of a percent.
module thss_conv (
  input  logic [thss_pkg::TEMP_PROD_W-1:0] temp_prod,
  input  logic [thss_pkg::HUM_PROD_W-1:0]  hum_prod,
  output logic signed [14:0]               temperature,
  output logic [13:0]                      humidity
);
  import thss_pkg::*;

  // Division by 65535: x = 65535*hi + (hi + lo), and hi + lo stays below twice 65535,
  // so one compare and subtract finishes the quotient.
  logic [14:0] t_hi;
  logic [16:0] t_rem;
  logic        t_ge;
  logic [14:0] t_quo;
  logic        t_rem_nz;
  logic        t_corr;
  logic signed [15:0] t_val;

  logic [13:0] h_hi;
  logic [16:0] h_rem;
  logic        h_ge;

  // Temperature: truncation toward zero of (quotient - 4500) with the remainder kept.
  always_comb begin
    t_hi     = temp_prod[TEMP_PROD_W-1:16];
    t_rem    = {2'b00, t_hi} + {1'b0, temp_prod[15:0]};
    t_ge     = (t_rem >= FULL_SCALE);
    t_quo    = t_hi + {14'd0, t_ge};
    t_rem_nz = t_ge ? (t_rem != FULL_SCALE) : (t_rem != 17'd0);
    // A negative result with a remainder rounds up toward zero.
    t_corr   = (t_quo < TEMP_OFFSET[14:0]) && t_rem_nz;
    t_val    = $signed({1'b0, t_quo}) - $signed(TEMP_OFFSET) + $signed({15'd0, t_corr});
    temperature = t_val[14:0];
  end

  // Humidity: plain floor of the quotient.
  always_comb begin
    h_hi     = hum_prod[HUM_PROD_W-1:16];
    h_rem    = {3'b000, h_hi} + {1'b0, hum_prod[15:0]};
    h_ge     = (h_rem >= FULL_SCALE);
    humidity = h_hi + {13'd0, h_ge};
  end

endmodule

[hw/rtl/thss_seq.sv]
// Init and measurement sequencer: state registers and the decision for each event.
module thss_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [1:0]        mode,
  input  thss_pkg::cfg_t    cfg,
  output thss_pkg::seq_res_t res
);
  import thss_pkg::*;

  logic [2:0] pending;
  logic [2:0] pending_next;
  logic       wait_elapsed;
  logic       wait_elapsed_next;
  logic       measuring;
  logic       measuring_next;
  logic       init_complete;
  logic       init_complete_next;

  // Decision logic: init chain first, then measurement chain on the updated command.
  always_comb begin
    pending_next       = pending;
    wait_elapsed_next  = wait_elapsed;
    measuring_next     = measuring;
    init_complete_next = init_complete;
    res                = '0;

    case (mode)
      MODE_INIT: begin
        pending_next       = PC_SRESET;
        wait_elapsed_next  = 1'b0;
        measuring_next     = 1'b0;
        init_complete_next = 1'b0;
        res.action         = ACT_WRITE;
        res.command_word   = CMD_SRESET;
      end
      MODE_REQUEST: begin
        if (!init_complete) begin
          res.request_status = STATUS_NO_INIT;
        end else if (measuring || (pending != PC_NONE)) begin
          res.request_status = STATUS_BUSY;
        end else begin
          measuring_next   = 1'b1;
          pending_next     = PC_MSTART;
          res.action       = ACT_WRITE;
          res.command_word = CMD_MSTART;
        end
      end
      default: begin
        // A timer event marks the wait as over, even a stray one.
        if (mode == MODE_TIMER) begin
          wait_elapsed_next = 1'b1;
        end
        if (!init_complete) begin
          case (pending)
            PC_NONE: begin
              pending_next     = PC_SRESET;
              res.action       = ACT_WRITE;
              res.command_word = CMD_SRESET;
            end
            PC_SRESET: begin
              if (!wait_elapsed_next) begin
                res.action  = ACT_WAIT;
                res.wait_ms = cfg.reset_wait_ms;
              end else begin
                wait_elapsed_next = 1'b0;
                pending_next      = PC_CLEAR;
                res.action        = ACT_WRITE;
                res.command_word  = CMD_CLEAR;
              end
            end
            PC_CLEAR: begin
              res.action = ACT_WRITE;
              if (cfg.heater_enable) begin
                pending_next     = PC_HEAT_ON;
                res.command_word = CMD_HEAT_ON;
              end else begin
                pending_next     = PC_HEAT_OFF;
                res.command_word = CMD_HEAT_OFF;
              end
            end
            PC_HEAT_ON, PC_HEAT_OFF: begin
              pending_next       = PC_NONE;
              init_complete_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
        // Measurement chain.
        if (pending_next == PC_MSTART) begin
          if (!wait_elapsed_next) begin
            res.action  = ACT_WAIT;
            res.wait_ms = cfg.measure_wait_ms;
          end else begin
            wait_elapsed_next = 1'b0;
            pending_next      = PC_READ;
            res.action        = ACT_READ;
          end
        end else if (pending_next == PC_READ) begin
          res.action     = ACT_REPORT;
          res.report     = 1'b1;
          measuring_next = 1'b0;
          pending_next   = PC_NONE;
        end
      end
    endcase

    res.ready_res = init_complete_next;
  end

  // State update on each event that moves on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= PC_NONE;
      wait_elapsed  <= 1'b0;
      measuring     <= 1'b0;
      init_complete <= 1'b0;
    end else if (advance) begin
      pending       <= pending_next;
      wait_elapsed  <= wait_elapsed_next;
      measuring     <= measuring_next;
      init_complete <= init_complete_next;
    end
  end

endmodule
